@@ rtl/circular_queue_with_remove_at_top_defines.svh @@
// Assertion macros used by the checker file of the queue.
`ifndef CIRCULAR_QUEUE_WITH_REMOVE_AT_TOP_DEFINES_SVH
`define CIRCULAR_QUEUE_WITH_REMOVE_AT_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define CQRAT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("queue check failed");

// Next-cycle implication, disabled while reset is held.
`define CQRAT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("queue check failed");

`endif

@@ rtl/cqrat_pkg.sv @@
package cqrat_pkg;

    localparam int VAL_W = 32;

    localparam logic [1:0] OP_ENQ = 2'd0;
    localparam logic [1:0] OP_DEQ = 2'd1;
    localparam logic [1:0] OP_REM = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_FULL   = 2'd1;
    localparam logic [1:0] ST_EMPTY  = 2'd2;
    localparam logic [1:0] ST_BADPOS = 2'd3;

    typedef struct packed {
        logic [1:0]              op;
        logic signed [VAL_W-1:0] item_value;
        logic [3:0]              position;
    } t_in_item;

    typedef struct packed {
        logic signed [VAL_W-1:0] removed_value;
        logic [1:0]              status;
        logic [4:0]              occupancy;
        logic                    is_empty;
        logic                    is_full;
    } t_out_item;

endpackage

@@ rtl/cqrat_ram.sv @@
module cqrat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/circular_queue_with_remove_at_top.sv @@
// Ring-buffer queue of signed 32-bit values with removal at a position.
// Input channel (i_in_valid, o_in_stall, i_in): one request per beat, either
// enqueue, dequeue or remove the entry at an offset from the head.
// Output channel (o_out_valid, i_out_stall, o_out): exactly one result beat
// per request, carrying the removed value, a status code, the occupancy
// after the request and empty and full flags. Results come in request order.
// The entries live in one memory with one write and one registered read
// port, so a removal moves the later entries one at a time.
// An enqueue, a failed request or an unused code goes from S_IDLE straight
// to S_DONE; a dequeue first captures the head entry in S_RD; a removal
// captures the addressed entry in S_RD, then slides each later entry toward
// the head in S_SHIFT, that is occupancy - 1 - position entries.
// A new request is taken once the previous result sits in the output
// register, even while that result is still stalled; a stalled output
// holds the following result back in the block until the register frees.
// A request is never taken while an earlier one is still in progress.
// Reset empties the queue (head at slot zero, tail at the last slot) and
// drops any pending result; the memory contents are not cleared.
module circular_queue_with_remove_at_top #(
    parameter int DEPTH = 16
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  cqrat_pkg::t_in_item  i_in,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output cqrat_pkg::t_out_item o_out
);

    localparam int AW  = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW  = $clog2(DEPTH + 1);
    localparam int PCW = (CW > 4) ? CW : 4;
    localparam int SW  = ((AW > 4) ? AW : 4) + 1;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_RD    = 4'b0010,
        S_SHIFT = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic [AW-1:0] r_head, n_head;
    logic [AW-1:0] r_tail, n_tail;
    logic [CW-1:0] r_count, n_count;
    logic [AW-1:0] r_src, n_src;
    logic [AW-1:0] r_dst, n_dst;
    logic [CW-1:0] r_left, n_left;
    logic          r_is_rem, n_is_rem;
    logic signed [cqrat_pkg::VAL_W-1:0] r_removed, n_removed;
    logic [1:0]    r_status, n_status;
    logic          r_out_valid, n_out_valid;
    cqrat_pkg::t_out_item r_out, n_out;

    logic                         w_we;
    logic [AW-1:0]                w_waddr;
    logic [cqrat_pkg::VAL_W-1:0]  w_wdata;
    logic [AW-1:0]                w_raddr;
    logic [cqrat_pkg::VAL_W-1:0]  w_rdata;

    logic          w_accept;
    logic [PCW-1:0] w_pos_ext;
    logic [PCW-1:0] w_cnt_ext;
    logic [SW-1:0]  w_sum;
    logic [AW-1:0]  w_slot;
    logic [CW-1:0]  w_take_cnt;

    function automatic logic [AW-1:0] f_inc(input logic [AW-1:0] p);
        f_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [AW-1:0] f_dec(input logic [AW-1:0] p);
        f_dec = (p == '0) ? AW'(DEPTH - 1) : p - 1'b1;
    endfunction

    cqrat_ram #(
        .WIDTH(cqrat_pkg::VAL_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    assign w_accept   = i_in_valid && (r_state == S_IDLE);
    assign w_pos_ext  = PCW'(i_in.position);
    assign w_cnt_ext  = PCW'(r_count);
    assign w_take_cnt = r_count - 1'b1;

    // Physical slot of the addressed entry; the position is below the
    // occupancy whenever it is used, so one wrap correction is enough.
    always_comb begin
        w_sum = SW'(r_head) + SW'(i_in.position);
        if (w_sum >= SW'(DEPTH)) begin
            w_sum = w_sum - SW'(DEPTH);
        end
        w_slot = AW'(w_sum);
    end

    always_comb begin
        n_state     = r_state;
        n_head      = r_head;
        n_tail      = r_tail;
        n_count     = r_count;
        n_src       = r_src;
        n_dst       = r_dst;
        n_left      = r_left;
        n_is_rem    = r_is_rem;
        n_removed   = r_removed;
        n_status    = r_status;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        w_we        = 1'b0;
        w_waddr     = r_dst;
        w_wdata     = w_rdata;
        w_raddr     = r_head;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_removed = '0;
                    n_status  = cqrat_pkg::ST_OK;
                    n_state   = S_DONE;
                    case (i_in.op)
                        cqrat_pkg::OP_ENQ: begin
                            if (r_count == CW'(DEPTH)) begin
                                n_status = cqrat_pkg::ST_FULL;
                            end else begin
                                w_we    = 1'b1;
                                w_waddr = f_inc(r_tail);
                                w_wdata = i_in.item_value;
                                n_tail  = f_inc(r_tail);
                                n_count = r_count + 1'b1;
                            end
                        end
                        cqrat_pkg::OP_DEQ: begin
                            if (r_count == '0) begin
                                n_status = cqrat_pkg::ST_EMPTY;
                            end else begin
                                w_raddr  = r_head;
                                n_is_rem = 1'b0;
                                n_state  = S_RD;
                            end
                        end
                        cqrat_pkg::OP_REM: begin
                            if (r_count == '0 || w_pos_ext >= w_cnt_ext) begin
                                n_status = cqrat_pkg::ST_BADPOS;
                            end else begin
                                w_raddr  = w_slot;
                                n_src    = w_slot;
                                n_left   = CW'(w_cnt_ext - w_pos_ext - 1'b1);
                                n_is_rem = 1'b1;
                                n_state  = S_RD;
                            end
                        end
                        default: begin
                            n_status = cqrat_pkg::ST_OK;
                        end
                    endcase
                end
            end
            S_RD: begin
                n_removed = w_rdata;
                if (!r_is_rem) begin
                    n_head  = f_inc(r_head);
                    n_count = w_take_cnt;
                    if (w_take_cnt == '0) begin
                        n_head = '0;
                        n_tail = AW'(DEPTH - 1);
                    end
                    n_state = S_DONE;
                end else if (r_left == '0) begin
                    n_tail  = f_dec(r_tail);
                    n_count = w_take_cnt;
                    if (w_take_cnt == '0) begin
                        n_head = '0;
                        n_tail = AW'(DEPTH - 1);
                    end
                    n_state = S_DONE;
                end else begin
                    // Start the slide: fetch the next entry, it lands in the gap.
                    w_raddr = f_inc(r_src);
                    n_dst   = r_src;
                    n_src   = f_inc(r_src);
                    n_state = S_SHIFT;
                end
            end
            S_SHIFT: begin
                // The write goes two slots behind the read, so they never collide.
                w_we    = 1'b1;
                w_waddr = r_dst;
                w_wdata = w_rdata;
                n_left  = r_left - 1'b1;
                if (r_left == CW'(1)) begin
                    n_tail  = f_dec(r_tail);
                    n_count = w_take_cnt;
                    n_state = S_DONE;
                end else begin
                    w_raddr = f_inc(r_src);
                    n_dst   = r_src;
                    n_src   = f_inc(r_src);
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out.removed_value = r_removed;
                    n_out.status        = r_status;
                    n_out.occupancy     = 5'(r_count);
                    n_out.is_empty      = (r_count == '0);
                    n_out.is_full       = (r_count == CW'(DEPTH));
                    n_out_valid         = 1'b1;
                    n_state             = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_head      <= '0;
            r_tail      <= AW'(DEPTH - 1);
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_head      <= n_head;
            r_tail      <= n_tail;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_src     <= n_src;
        r_dst     <= n_dst;
        r_left    <= n_left;
        r_is_rem  <= n_is_rem;
        r_removed <= n_removed;
        r_status  <= n_status;
        r_out     <= n_out;
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule

@@ rtl/cqrat_checker.sv @@
`include "circular_queue_with_remove_at_top_defines.svh"

module cqrat_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_stall,
    input cqrat_pkg::t_in_item  i_in,
    input logic                 o_out_valid,
    input logic                 i_out_stall,
    input cqrat_pkg::t_out_item o_out
);

    logic w_in_beat;
    logic w_out_hold;

    assign w_in_beat  = i_in_valid && !o_in_stall;
    assign w_out_hold = o_out_valid && i_out_stall;

    // A stalled result stays put.
    `CQRAT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, w_out_hold, o_out_valid && $stable(o_out))

    // An accepted request stalls the input before the next one is taken.
    `CQRAT_ASSERT_NEXT(a_one_at_a_time, i_clk, i_rst_n, w_in_beat, o_in_stall)

    // A full rejection reports a full queue and returns nothing.
    `CQRAT_ASSERT_NOW(a_full_status, i_clk, i_rst_n,
        o_out_valid && o_out.status == cqrat_pkg::ST_FULL,
        o_out.is_full && o_out.removed_value == '0)

    // An empty rejection reports an empty queue with no entries left.
    `CQRAT_ASSERT_NOW(a_empty_status, i_clk, i_rst_n,
        o_out_valid && o_out.status == cqrat_pkg::ST_EMPTY,
        o_out.is_empty && o_out.occupancy == '0 && o_out.removed_value == '0)

endmodule

bind circular_queue_with_remove_at_top cqrat_checker u_cqrat_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_in_valid (i_in_valid),
    .o_in_stall (o_in_stall),
    .i_in       (i_in),
    .o_out_valid(o_out_valid),
    .i_out_stall(i_out_stall),
    .o_out      (o_out)
);
